// File: rtl/mbff_pkg.sv
package mbff_pkg;

    localparam int NODE_W             = 24;
    localparam int OWNER_W            = 24;
    localparam int SIZE_W             = 4;
    localparam int SLOT_W             = 8;
    localparam int STATUS_W           = 3;
    localparam int IN_NODES           = 8;
    localparam int MAX_CORNERS        = 4;
    localparam int CORNER_W           = 3;
    localparam int DEF_TABLE_DEPTH    = 256;
    localparam int DEF_MAX_FACE_NODES = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_MATCHED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_READ_OK   = 3'd3,
        ST_READ_MISS = 3'd4
    } status_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    function automatic logic [CORNER_W-1:0] corner_count(input logic [SIZE_W-1:0] cnt);
        logic [CORNER_W-1:0] result;
        if (cnt > SIZE_W'(MAX_CORNERS)) begin
            result = cnt[SIZE_W-1:1];
        end else begin
            result = cnt[CORNER_W-1:0];
        end
        return result;
    endfunction

endpackage

// File: rtl/mbff_cell.sv
module mbff_cell #(
    parameter int ENTRY_W = 1
) (
    input  logic                  aclk,
    input  mbff_pkg::cell_ctl_t   ctl,
    input  logic [ENTRY_W-1:0]    shift_in,
    input  logic [ENTRY_W-1:0]    load_in,
    output logic [ENTRY_W-1:0]    entry
);

    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.load) begin
            entry_next = load_in;
        end else if (ctl.shift) begin
            entry_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/mbff_head.sv
module mbff_head #(
    parameter int MAX_FACE_NODES = mbff_pkg::DEF_MAX_FACE_NODES
) (
    input  logic                                            enable,
    input  logic [MAX_FACE_NODES-1:0][mbff_pkg::NODE_W-1:0] head_nodes,
    input  logic [MAX_FACE_NODES-1:0][mbff_pkg::NODE_W-1:0] cand_nodes,
    input  logic [mbff_pkg::CORNER_W-1:0]                   ncorner,
    input  logic                                            outer_in,
    output logic                                            match,
    output logic                                            outer_out
);

    localparam int CORNERS = (MAX_FACE_NODES < mbff_pkg::MAX_CORNERS) ?
                             MAX_FACE_NODES : mbff_pkg::MAX_CORNERS;

    logic all_found;

    always_comb begin
        logic present;
        all_found = 1'b1;
        for (int k = 0; k < CORNERS; k++) begin
            present = 1'b0;
            for (int j = 0; j < CORNERS; j++) begin
                if ((mbff_pkg::CORNER_W'(j) < ncorner) && (head_nodes[j] == cand_nodes[k])) begin
                    present = 1'b1;
                end
            end
            if ((mbff_pkg::CORNER_W'(k) < ncorner) && !present) begin
                all_found = 1'b0;
            end
        end
    end

    assign match     = enable && outer_in && all_found;
    assign outer_out = outer_in && !match;

endmodule

// File: rtl/mesh_boundary_face_filter_unit.sv
// Boundary face filter over a table of up to TABLE_DEPTH faces.
// Input channel s_*: one transaction per op (insert face, read entry, clear).
// Result channel m_*: exactly one transaction per accepted op.
// The table lives in a ring of TABLE_DEPTH cells; an insert or an in-range
// read rotates the ring once past a single head comparator, then goes to
// the finish state. A clear, an idle op, a read beyond the stored count,
// or an insert into an empty table goes straight to the finish state.
// The ring rotation sets the rate: one item at a time, at most one table
// entry per cycle. s_ready rises again as soon as the op has been retired
// into the output register, even while that result still waits.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result; table contents are not cleared and are never read before written.
// When the receiver stalls, the result holds in the output register and a
// finished op waits in its last state until the register frees up.
module mesh_boundary_face_filter_unit #(
    parameter int TABLE_DEPTH    = mbff_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_FACE_NODES = mbff_pkg::DEF_MAX_FACE_NODES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_opcode,
    input  logic [mbff_pkg::NODE_W-1:0]     s_node_a,
    input  logic [mbff_pkg::NODE_W-1:0]     s_node_b,
    input  logic [mbff_pkg::NODE_W-1:0]     s_node_c,
    input  logic [mbff_pkg::NODE_W-1:0]     s_node_d,
    input  logic [mbff_pkg::NODE_W-1:0]     s_node_e,
    input  logic [mbff_pkg::NODE_W-1:0]     s_node_f,
    input  logic [mbff_pkg::NODE_W-1:0]     s_node_g,
    input  logic [mbff_pkg::NODE_W-1:0]     s_node_h,
    input  logic [mbff_pkg::SIZE_W-1:0]     s_node_count,
    input  logic [mbff_pkg::OWNER_W-1:0]    s_owner_element,
    input  logic [mbff_pkg::SLOT_W-1:0]     s_read_slot,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mbff_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_is_outer,
    output logic [mbff_pkg::OWNER_W-1:0]    m_entry_element,
    output logic [mbff_pkg::SIZE_W-1:0]     m_entry_count,
    output logic [mbff_pkg::NODE_W-1:0]     m_out_node_a,
    output logic [mbff_pkg::NODE_W-1:0]     m_out_node_b,
    output logic [mbff_pkg::NODE_W-1:0]     m_out_node_c,
    output logic [mbff_pkg::NODE_W-1:0]     m_out_node_d,
    output logic [mbff_pkg::NODE_W-1:0]     m_out_node_e,
    output logic [mbff_pkg::NODE_W-1:0]     m_out_node_f,
    output logic [mbff_pkg::NODE_W-1:0]     m_out_node_g,
    output logic [mbff_pkg::NODE_W-1:0]     m_out_node_h
);

    localparam int NODE_W    = mbff_pkg::NODE_W;
    localparam int SIZE_W    = mbff_pkg::SIZE_W;
    localparam int OWNER_W   = mbff_pkg::OWNER_W;
    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > mbff_pkg::SLOT_W) ? CNT_W : mbff_pkg::SLOT_W;
    localparam int NODES_W   = MAX_FACE_NODES * NODE_W;
    localparam int OWNER_LSB = NODES_W;
    localparam int SIZE_LSB  = NODES_W + OWNER_W;
    localparam int OUTER_BIT = SIZE_LSB + SIZE_W;
    localparam int ENTRY_W   = OUTER_BIT + 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    typedef logic [MAX_FACE_NODES-1:0][NODE_W-1:0] nodes_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              stored_reg, stored_next;
    logic                          found_reg, found_next;
    mbff_pkg::opcode_t             op_reg, op_next;
    nodes_t                        cand_reg, cand_next;
    logic [SIZE_W-1:0]             cnt_reg, cnt_next;
    logic [mbff_pkg::CORNER_W-1:0] ncorner_reg, ncorner_next;
    logic [OWNER_W-1:0]            owner_reg, owner_next;
    logic [mbff_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [ENTRY_W-1:0]            rd_reg, rd_next;
    logic                          m_valid_reg, m_valid_next;
    logic [mbff_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          outer_reg, outer_next;
    logic [OWNER_W-1:0]            element_reg, element_next;
    logic [SIZE_W-1:0]             count_reg, count_next;
    logic [NODE_W-1:0]             onode_reg [mbff_pkg::IN_NODES];
    logic [NODE_W-1:0]             onode_next [mbff_pkg::IN_NODES];

    logic [NODE_W-1:0]  in_nodes [mbff_pkg::IN_NODES];
    logic [SIZE_W-1:0]  cnt_sat;
    logic               accept;
    logic               out_free;
    logic               scan_active;
    logic               in_range;
    logic               head_enable;
    logic               head_match;
    logic               head_outer;
    logic               load_go;
    logic               slot_valid;
    logic [ENTRY_W-1:0] head_wb;
    logic [ENTRY_W-1:0] load_data;
    logic [ENTRY_W-1:0] ring [TABLE_DEPTH];

    assign in_nodes[0] = s_node_a;
    assign in_nodes[1] = s_node_b;
    assign in_nodes[2] = s_node_c;
    assign in_nodes[3] = s_node_d;
    assign in_nodes[4] = s_node_e;
    assign in_nodes[5] = s_node_f;
    assign in_nodes[6] = s_node_g;
    assign in_nodes[7] = s_node_h;

    assign cnt_sat = (s_node_count > SIZE_W'(MAX_FACE_NODES)) ?
                     SIZE_W'(MAX_FACE_NODES) : s_node_count;

    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign scan_active = (state_reg == S_SCAN);
    assign in_range    = (CNT_W'(idx_reg) < stored_reg);
    assign slot_valid  = (CMP_W'(slot_reg) < CMP_W'(stored_reg));
    assign head_enable = scan_active && (op_reg == mbff_pkg::OP_INSERT) && !found_reg && in_range;
    assign load_go     = (state_reg == S_FINISH) && out_free && (op_reg == mbff_pkg::OP_INSERT)
                         && !found_reg && (stored_reg != CNT_W'(TABLE_DEPTH));
    assign load_data   = {1'b1, cnt_reg, owner_reg, cand_reg};
    assign head_wb     = {head_outer, ring[0][OUTER_BIT-1:0]};

    mbff_head #(
        .MAX_FACE_NODES(MAX_FACE_NODES)
    ) u_head (
        .enable    (head_enable),
        .head_nodes(ring[0][NODES_W-1:0]),
        .cand_nodes(cand_reg),
        .ncorner   (ncorner_reg),
        .outer_in  (ring[0][OUTER_BIT]),
        .match     (head_match),
        .outer_out (head_outer)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
        mbff_pkg::cell_ctl_t ctl;
        logic [ENTRY_W-1:0]  shift_in;

        assign ctl.shift = scan_active;
        assign ctl.load  = load_go && (stored_reg[IDX_W-1:0] == IDX_W'(i));

        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign shift_in = head_wb;
        end else begin : g_body
            assign shift_in = ring[i+1];
        end

        mbff_cell #(
            .ENTRY_W(ENTRY_W)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .shift_in(shift_in),
            .load_in (load_data),
            .entry   (ring[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        stored_next  = stored_reg;
        found_next   = found_reg;
        op_next      = op_reg;
        cand_next    = cand_reg;
        cnt_next     = cnt_reg;
        ncorner_next = ncorner_reg;
        owner_next   = owner_reg;
        slot_next    = slot_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        outer_next   = outer_reg;
        element_next = element_reg;
        count_next   = count_reg;
        for (int p = 0; p < mbff_pkg::IN_NODES; p++) begin
            onode_next[p] = onode_reg[p];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next      = mbff_pkg::opcode_t'(s_opcode);
                    cnt_next     = cnt_sat;
                    ncorner_next = mbff_pkg::corner_count(cnt_sat);
                    owner_next   = s_owner_element;
                    slot_next    = s_read_slot;
                    found_next   = 1'b0;
                    idx_next     = '0;
                    for (int p = 0; p < MAX_FACE_NODES; p++) begin
                        cand_next[p] = in_nodes[p];
                    end
                    state_next = S_FINISH;
                    if ((mbff_pkg::opcode_t'(s_opcode) == mbff_pkg::OP_INSERT)
                        && (stored_reg != '0)) begin
                        state_next = S_SCAN;
                    end
                    if ((mbff_pkg::opcode_t'(s_opcode) == mbff_pkg::OP_READ)
                        && (CMP_W'(s_read_slot) < CMP_W'(stored_reg))) begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (head_match) begin
                    found_next = 1'b1;
                end
                if ((op_reg == mbff_pkg::OP_READ) && (CMP_W'(idx_reg) == CMP_W'(slot_reg))) begin
                    rd_next = ring[0];
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    idx_next   = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    outer_next   = 1'b0;
                    element_next = '0;
                    count_next   = '0;
                    for (int p = 0; p < mbff_pkg::IN_NODES; p++) begin
                        onode_next[p] = '0;
                    end
                    unique case (op_reg)
                        mbff_pkg::OP_INSERT: begin
                            if (found_reg) begin
                                status_next = mbff_pkg::ST_MATCHED;
                            end else if (stored_reg == CNT_W'(TABLE_DEPTH)) begin
                                status_next = mbff_pkg::ST_FULL;
                            end else begin
                                status_next = mbff_pkg::ST_STORED;
                                stored_next = stored_reg + 1'b1;
                            end
                        end
                        mbff_pkg::OP_READ: begin
                            if (slot_valid) begin
                                status_next  = mbff_pkg::ST_READ_OK;
                                outer_next   = rd_reg[OUTER_BIT];
                                element_next = rd_reg[OWNER_LSB +: OWNER_W];
                                count_next   = rd_reg[SIZE_LSB +: SIZE_W];
                                for (int p = 0; p < MAX_FACE_NODES; p++) begin
                                    onode_next[p] = rd_reg[p*NODE_W +: NODE_W];
                                end
                            end else begin
                                status_next = mbff_pkg::ST_READ_MISS;
                            end
                        end
                        mbff_pkg::OP_CLEAR: begin
                            status_next = mbff_pkg::ST_STORED;
                            stored_next = '0;
                        end
                        default: begin
                            status_next = mbff_pkg::ST_STORED;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            stored_reg  <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            stored_reg  <= stored_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        cand_reg    <= cand_next;
        cnt_reg     <= cnt_next;
        ncorner_reg <= ncorner_next;
        owner_reg   <= owner_next;
        slot_reg    <= slot_next;
        rd_reg      <= rd_next;
        status_reg  <= status_next;
        outer_reg   <= outer_next;
        element_reg <= element_next;
        count_reg   <= count_next;
        for (int p = 0; p < mbff_pkg::IN_NODES; p++) begin
            onode_reg[p] <= onode_next[p];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_is_outer      = outer_reg;
    assign m_entry_element = element_reg;
    assign m_entry_count   = count_reg;
    assign m_out_node_a    = onode_reg[0];
    assign m_out_node_b    = onode_reg[1];
    assign m_out_node_c    = onode_reg[2];
    assign m_out_node_d    = onode_reg[3];
    assign m_out_node_e    = onode_reg[4];
    assign m_out_node_f    = onode_reg[5];
    assign m_out_node_g    = onode_reg[6];
    assign m_out_node_h    = onode_reg[7];

    // ring must be back in slot order whenever it is not rotating
    a_ring_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_SCAN) |-> (idx_reg == '0))
        else $error("ring index not aligned outside scan");

    a_stored_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_reg <= CNT_W'(TABLE_DEPTH))
        else $error("stored face count beyond table depth");

    a_scan_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_active |=> (stored_reg == $past(stored_reg)))
        else $error("stored face count changed during scan");

    a_append_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        load_go |=> (stored_reg == $past(stored_reg) + 1'b1)
                    && (status_reg == mbff_pkg::ST_STORED))
        else $error("append did not advance stored face count");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg && scan_active |-> !head_match)
        else $error("second match in one scan");

endmodule
